// ===== rtl/tgd_pkg.sv =====
// Shared types, codes and constants for the twist gesture detector.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package tgd_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ITER_W       = 4;
   localparam int ANGLE_LIMIT  = 11520;
   localparam int ONE_UNIT     = 256;
   localparam int TRIM_LIMIT   = 21;
   localparam int SAT_MAX      = 255;

   // transaction op codes
   localparam logic OP_ACCEL  = 1'b0;
   localparam logic OP_ORIENT = 1'b1;

   // orientation codes
   localparam logic [2:0] ORI_TOP_DOWN  = 3'd2;
   localparam logic [2:0] ORI_LEFT_UP   = 3'd3;
   localparam logic [2:0] ORI_RIGHT_UP  = 3'd4;
   localparam logic [2:0] ORI_FACE_UP   = 3'd5;
   localparam logic [2:0] ORI_FACE_DOWN = 3'd6;

   // detected sign codes
   localparam logic [1:0] SIGN_ZERO = 2'd0;
   localparam logic [1:0] SIGN_POS  = 2'd1;
   localparam logic [1:0] SIGN_NEG  = 2'd2;

   // gesture codes
   localparam logic [1:0] GEST_NONE  = 2'd0;
   localparam logic [1:0] GEST_LEFT  = 2'd1;
   localparam logic [1:0] GEST_RIGHT = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_MIN_ANGLE    = 3'd0;
   localparam logic [2:0] CSR_DETECT_ANGLE = 3'd1;
   localparam logic [2:0] CSR_RETURN_ANGLE = 3'd2;
   localparam logic [2:0] CSR_Z_RESET      = 3'd3;
   localparam logic [2:0] CSR_X_MIN        = 3'd4;

   typedef struct packed {
      logic [13:0] min_angle;
      logic [13:0] detect_angle;
      logic [13:0] return_angle;
      logic [14:0] z_reset_limit;
      logic [14:0] x_min;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic prod;
      logic sqrt_step;
      logic cord_step;
      logic eval;
      logic check;
      logic walk;
      logic post;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_orient;
      logic acc_skip;
      logic iter_last;
      logic chk_pend;
      logic need_walk;
      logic walk_done;
      logic rsp_busy;
   } sts_type;

   // atan(2^-i) in 2^-16 degree
   function automatic logic [21:0] atan_entry(input logic [ITER_W-1:0] i);
      logic [21:0] v;
      case (i)
         4'd0:  v = 22'd2949120;
         4'd1:  v = 22'd1740967;
         4'd2:  v = 22'd919879;
         4'd3:  v = 22'd466945;
         4'd4:  v = 22'd234379;
         4'd5:  v = 22'd117304;
         4'd6:  v = 22'd58666;
         4'd7:  v = 22'd29335;
         4'd8:  v = 22'd14668;
         4'd9:  v = 22'd7334;
         4'd10: v = 22'd3667;
         4'd11: v = 22'd1833;
         4'd12: v = 22'd917;
         4'd13: v = 22'd458;
         4'd14: v = 22'd229;
         4'd15: v = 22'd115;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/twist_gesture_detector_unit.sv =====
// Top level of the twist gesture detector: configuration registers and assertions.
// Depends on tgd_pkg, tgd_ctrl and tgd_datapath.
`timescale 1ns / 1ps

// Twist gesture detector. Each req transaction is either an accelerometer sample
// (op 0, x/y/z in 1/256 m/s^2) or an orientation event (op 1), and yields exactly
// one rsp transaction carrying the gesture code (none, twist left, twist right).
// The block works on one transaction at a time; req_stall stays high from accept
// until the result has been moved into the output register. An accelerometer
// sample runs a digit-by-digit square root of y^2+z^2, then 16 CORDIC vectoring
// iterations for the tilt angle, then evaluation, a buffer walk when needed and
// the update. When a twist check falls through to the x-swing heuristic, the
// buffered samples are read back one per cycle from the sample memory.
// Orientation events skip the square root and CORDIC and go straight to
// evaluation, plus the same walk when one is needed. A sample before the first
// orientation event goes straight to the response. The output register lets the
// next transaction be accepted while a result is still held by a stalled consumer.
// The sample buffer is a circular memory with a head pointer and a fill count, so
// no clearing pass is needed after reset. Configuration is written through the
// csr port (always ready) and must only be written while the block is idle.

module twist_gesture_detector_unit #(
   parameter int SAMPLE_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [14:0]        csr_data,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic [2:0]         req_orientation,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_gesture
);

   tgd_pkg::cfg_type cfg_ff, cfg_in;
   tgd_pkg::cmd_type cmd;
   tgd_pkg::sts_type sts;
   logic             idle;
   logic             req_fire;

   // config registers; indexes past the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tgd_pkg::CSR_MIN_ANGLE:    cfg_in.min_angle     = csr_data[13:0];
            tgd_pkg::CSR_DETECT_ANGLE: cfg_in.detect_angle  = csr_data[13:0];
            tgd_pkg::CSR_RETURN_ANGLE: cfg_in.return_angle  = csr_data[13:0];
            tgd_pkg::CSR_Z_RESET:      cfg_in.z_reset_limit = csr_data;
            tgd_pkg::CSR_X_MIN:        cfg_in.x_min         = csr_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_angle     <= 14'd256;   // 2 degrees
         cfg_ff.detect_angle  <= 14'd3840;  // 30 degrees
         cfg_ff.return_angle  <= 14'd3200;  // 25 degrees
         cfg_ff.z_reset_limit <= 15'd3840;  // 15 m/s^2
         cfg_ff.x_min         <= 15'd256;   // 1 m/s^2
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign req_stall = !idle;
   assign req_fire  = req_valid && !req_stall;

   tgd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .sts      (sts),
      .cmd      (cmd),
      .idle     (idle)
   );

   tgd_datapath #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_op),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .req_orientation (req_orientation),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_gesture     (rsp_gesture)
   );

   // one transaction in flight: an accept closes the request side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> req_stall)
      else $error("request side open right after accept");

   // the controller never issues two commands at once
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.prod, cmd.sqrt_step, cmd.cord_step, cmd.eval,
                cmd.check, cmd.walk, cmd.post, cmd.rsp_load}))
      else $error("overlapping datapath commands");

   // a result load always shows up on the port
   a_rsp_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid && rsp_gesture != 2'd3)
      else $error("result load lost or bad gesture code");

endmodule

// ===== rtl/tgd_ctrl.sv =====
// Sequencing state machine for the twist gesture detector.
// Depends on tgd_pkg for the command and status structs.
`timescale 1ns / 1ps

module tgd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_fire,
   input  tgd_pkg::sts_type sts,
   output tgd_pkg::cmd_type cmd,
   output logic             idle
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_PROD = 9'b000000010,
      ST_SQRT = 9'b000000100,
      ST_CORD = 9'b000001000,
      ST_EVAL = 9'b000010000,
      ST_CHK  = 9'b000100000,
      ST_WALK = 9'b001000000,
      ST_POST = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               if (sts.is_orient)
                  state_in = ST_EVAL;
               else if (sts.acc_skip)
                  state_in = ST_OUT;
               else
                  state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (sts.iter_last)
               state_in = ST_CORD;
         end
         ST_CORD: begin
            cmd.cord_step = 1'b1;
            if (sts.iter_last)
               state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            cmd.check = 1'b1;
            if (sts.chk_pend && sts.need_walk)
               state_in = ST_WALK;
            else
               state_in = ST_POST;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_done)
               state_in = ST_POST;
         end
         ST_POST: begin
            cmd.post = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign idle = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

endmodule

// ===== rtl/tgd_datapath.sv =====
// Datapath: sqrt and CORDIC units, tracker state, sample buffer, result register.
// Depends on tgd_pkg; driven by tgd_ctrl commands.
`timescale 1ns / 1ps

module tgd_datapath #(
   parameter int SAMPLE_DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  tgd_pkg::cfg_type    cfg,
   input  tgd_pkg::cmd_type    cmd,
   output tgd_pkg::sts_type    sts,
   input  logic                req_op,
   input  logic signed [15:0]  req_accel_x,
   input  logic signed [15:0]  req_accel_y,
   input  logic signed [15:0]  req_accel_z,
   input  logic [2:0]          req_orientation,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [1:0]          rsp_gesture
);

   localparam int AW = $clog2(SAMPLE_DEPTH);
   localparam int CW = $clog2(SAMPLE_DEPTH + 1);
   localparam int SW = AW + 1;

   // latched transaction
   logic               op_ff, op_in;
   logic signed [15:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [2:0]         ori_ff, ori_in;

   // tracker state
   logic               seen_ff, seen_in;
   logic [2:0]         hist_ff [3];
   logic [2:0]         hist_in [3];
   logic [1:0]         ocnt_ff, ocnt_in;
   logic               detect_ff, detect_in, check_ff, check_in;
   logic [7:0]         rise_ff, rise_in, fall_ff, fall_in;
   logic signed [14:0] prev_ff, prev_in;
   logic [1:0]         sign_ff, sign_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               chk_pend_ff, chk_pend_in;
   logic [1:0]         g_ff, g_in;

   // sqrt / cordic
   logic [tgd_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic [31:0]        rem_ff, rem_in, res_ff, res_in;
   logic signed [26:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [24:0] acc_ff, acc_in;

   // buffer walk
   logic [CW-1:0]      wk_idx_ff, wk_idx_in;
   logic               wk_pend_ff, wk_pend_in;
   logic               spin_ff, spin_in, ok_ff, ok_in;
   logic signed [7:0]  lastx_ff, lastx_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_gesture_ff, rsp_gesture_in;

   // sample memory
   logic [31:0]        sample_mem [SAMPLE_DEPTH];
   logic [31:0]        rd_data_ff;
   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_wa, mem_ra;
   logic [31:0]        mem_wd;

   // combinational helpers
   logic signed [31:0] prod_y, prod_z;
   logic [31:0]        sq_bit;
   logic [32:0]        sq_trial;
   logic signed [26:0] cd_dx, cd_dy;
   logic signed [24:0] cd_tab;
   logic signed [25:0] acc_rnd;
   logic signed [16:0] acc_q;
   logic signed [14:0] ang;
   logic [13:0]        mag;
   logic               a_pos, a_neg, p_pos, p_neg, a_gt, a_lt;
   logic [15:0]        abs_x, abs_z;
   logic               orule, low_counts, high_counts;
   logic [1:0]         mid_sign;
   logic [SW-1:0]      wsum, rsum;
   logic signed [15:0] sx;
   logic signed [16:0] sx_ext, abs_sx, sx_bias;
   logic signed [17:0] lx_ext, d_up, d_down;
   logic               skip, clr, walk_done;

   always_comb begin
      // sqrt and cordic step terms
      prod_y   = y_ff * y_ff;
      prod_z   = z_ff * z_ff;
      sq_bit   = 32'd1 << {~iter_ff, 1'b0};
      sq_trial = {1'b0, res_ff} + {1'b0, sq_bit};
      cd_dx    = vy_ff >>> iter_ff;
      cd_dy    = vx_ff >>> iter_ff;
      cd_tab   = $signed({3'b000, tgd_pkg::atan_entry(iter_ff)});

      // angle rounding and clamp
      acc_rnd = {acc_ff[24], acc_ff} + 26'sd256;
      acc_q   = acc_rnd[25:9];
      if (x_ff == 16'sd0)
         ang = '0;
      else if (acc_q > 17'sd11520)
         ang = 15'sd11520;
      else if (acc_q < -17'sd11520)
         ang = -15'sd11520;
      else
         ang = acc_q[14:0];
      mag   = ang[14] ? 14'(-ang) : ang[13:0];
      a_neg = ang[14];
      a_pos = !ang[14] && (ang != 15'sd0);
      p_neg = prev_ff[14];
      p_pos = !prev_ff[14] && (prev_ff != 15'sd0);
      a_gt  = ang > prev_ff;
      a_lt  = ang < prev_ff;
      abs_x = x_ff[15] ? (~x_ff + 16'd1) : x_ff;
      abs_z = z_ff[15] ? (~z_ff + 16'd1) : z_ff;

      // check rules
      orule       = (ocnt_ff == 2'd3) && (hist_ff[0] == hist_ff[2]) &&
                    (hist_ff[1] == tgd_pkg::ORI_LEFT_UP ||
                     hist_ff[1] == tgd_pkg::ORI_RIGHT_UP);
      low_counts  = (rise_ff < 8'd1) || (fall_ff < 8'd3);
      high_counts = (rise_ff > 8'd6) && (fall_ff > 8'd4);
      mid_sign    = (hist_ff[1] == tgd_pkg::ORI_RIGHT_UP) ? tgd_pkg::SIGN_POS
                                                          : tgd_pkg::SIGN_NEG;

      // circular buffer addressing
      wsum = SW'(head_ff) + SW'(cnt_ff);
      if (wsum >= SW'(SAMPLE_DEPTH))
         wsum = wsum - SW'(SAMPLE_DEPTH);
      rsum = SW'(head_ff) + SW'(wk_idx_ff);
      if (rsum >= SW'(SAMPLE_DEPTH))
         rsum = rsum - SW'(SAMPLE_DEPTH);

      // walk terms
      sx      = $signed(rd_data_ff[15:0]);
      sx_ext  = {sx[15], sx};
      abs_sx  = sx[15] ? -sx_ext : sx_ext;
      skip    = !spin_ff && (abs_sx < 17'sd256);
      lx_ext  = {{2{lastx_ff[7]}}, lastx_ff, 8'b0};
      d_up    = {sx_ext[16], sx_ext} - lx_ext;
      d_down  = lx_ext - {sx_ext[16], sx_ext};
      sx_bias = sx_ext + (sx[15] ? 17'sd255 : 17'sd0);
      walk_done = (wk_idx_ff == cnt_ff) && !wk_pend_ff;
   end

   always_comb begin
      op_in = op_ff; x_in = x_ff; y_in = y_ff; z_in = z_ff; ori_in = ori_ff;
      seen_in = seen_ff; hist_in = hist_ff; ocnt_in = ocnt_ff;
      detect_in = detect_ff; check_in = check_ff;
      rise_in = rise_ff; fall_in = fall_ff; prev_in = prev_ff; sign_in = sign_ff;
      head_in = head_ff; cnt_in = cnt_ff; chk_pend_in = chk_pend_ff; g_in = g_ff;
      iter_in = iter_ff; rem_in = rem_ff; res_in = res_ff;
      vx_in = vx_ff; vy_in = vy_ff; acc_in = acc_ff;
      wk_idx_in = wk_idx_ff; wk_pend_in = 1'b0;
      spin_in = spin_ff; ok_in = ok_ff; lastx_in = lastx_ff;
      mem_we = 1'b0; mem_re = 1'b0;
      mem_wa = wsum[AW-1:0]; mem_ra = rsum[AW-1:0];
      mem_wd = {z_ff, x_ff};
      clr = 1'b0;

      if (cmd.load) begin
         op_in  = req_op;
         x_in   = req_accel_x;
         y_in   = req_accel_y;
         z_in   = req_accel_z;
         ori_in = req_orientation;
         g_in   = tgd_pkg::GEST_NONE;
         if (req_op == tgd_pkg::OP_ORIENT) begin
            seen_in = 1'b1;
         end else if (seen_ff && !detect_ff && !check_ff &&
                      cnt_ff > CW'(tgd_pkg::TRIM_LIMIT)) begin
            // drop the oldest buffered sample
            head_in = (head_ff == AW'(SAMPLE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            cnt_in  = cnt_ff - 1'b1;
         end
      end

      if (cmd.prod) begin
         rem_in  = $unsigned(prod_y) + $unsigned(prod_z);
         res_in  = '0;
         iter_in = '0;
      end

      if (cmd.sqrt_step) begin
         if ({1'b0, rem_ff} >= sq_trial) begin
            rem_in = rem_ff - sq_trial[31:0];
            res_in = (res_ff >> 1) + sq_bit;
         end else begin
            res_in = res_ff >> 1;
         end
         iter_in = iter_ff + 1'b1;
         // seed the CORDIC with the finished root
         vx_in  = $signed({3'b000, res_in[15:0], 8'b0});
         vy_in  = $signed({{3{x_ff[15]}}, x_ff, 8'b0});
         acc_in = '0;
      end

      if (cmd.cord_step) begin
         if (!vy_ff[26]) begin
            vx_in  = vx_ff + cd_dx;
            vy_in  = vy_ff - cd_dy;
            acc_in = acc_ff + cd_tab;
         end else begin
            vx_in  = vx_ff - cd_dx;
            vy_in  = vy_ff + cd_dy;
            acc_in = acc_ff - cd_tab;
         end
         iter_in = iter_ff + 1'b1;
      end

      if (cmd.eval) begin
         if (op_ff == tgd_pkg::OP_ACCEL) begin
            if (mag > cfg.min_angle) begin
               if (detect_ff) begin
                  if ((a_pos && a_lt) || (a_neg && a_gt)) begin
                     if (fall_ff != 8'(tgd_pkg::SAT_MAX))
                        fall_in = fall_ff + 1'b1;
                  end else if (fall_ff != 8'd0) begin
                     fall_in = fall_ff - 1'b1;
                  end
               end
               if (!detect_ff && ((a_pos && a_gt) || (a_neg && a_lt)) &&
                   ((a_pos && p_pos) || (a_neg && p_neg))) begin
                  if (rise_ff != 8'(tgd_pkg::SAT_MAX))
                     rise_in = rise_ff + 1'b1;
               end else if (!detect_ff && rise_ff > 8'd3 && mag > cfg.detect_angle) begin
                  fall_in   = '0;
                  detect_in = 1'b1;
                  if (y_ff > 16'sd0)
                     sign_in = tgd_pkg::SIGN_POS;
                  else if (y_ff < 16'sd0)
                     sign_in = tgd_pkg::SIGN_NEG;
                  else
                     sign_in = tgd_pkg::SIGN_ZERO;
               end
            end else begin
               rise_in = '0;
            end
            prev_in     = ang;
            chk_pend_in = detect_in && (fall_in >= 8'd4) && (mag < cfg.return_angle);
         end else begin
            case (ocnt_ff)
               2'd0: begin
                  hist_in[0] = ori_ff;
                  ocnt_in    = 2'd1;
               end
               2'd1: begin
                  hist_in[1] = ori_ff;
                  ocnt_in    = 2'd2;
               end
               2'd2: begin
                  hist_in[2] = ori_ff;
                  ocnt_in    = 2'd3;
               end
               default: begin
                  hist_in[0] = hist_ff[1];
                  hist_in[1] = hist_ff[2];
                  hist_in[2] = ori_ff;
                  ocnt_in    = 2'd3;
               end
            endcase
            chk_pend_in = (ocnt_in == 2'd3) && (hist_in[2] == tgd_pkg::ORI_FACE_UP) &&
                          (hist_in[1] == tgd_pkg::ORI_RIGHT_UP ||
                           hist_in[1] == tgd_pkg::ORI_LEFT_UP);
         end
      end

      if (cmd.check && chk_pend_ff) begin
         check_in = 1'b1;
         if (sign_ff == tgd_pkg::SIGN_NEG) begin
            clr = 1'b1;
         end else if (ocnt_ff < 2'd2) begin
            clr = 1'b0;
         end else if (orule || (!low_counts && high_counts)) begin
            sign_in = mid_sign;
            g_in    = (mid_sign == tgd_pkg::SIGN_POS) ? tgd_pkg::GEST_LEFT
                                                      : tgd_pkg::GEST_RIGHT;
            clr     = 1'b1;
         end else if (!low_counts) begin
            wk_idx_in = '0;
            spin_in   = 1'b0;
            ok_in     = 1'b0;
            lastx_in  = '0;
         end
      end

      if (cmd.walk) begin
         if (wk_idx_ff != cnt_ff) begin
            mem_re     = 1'b1;
            wk_idx_in  = wk_idx_ff + 1'b1;
            wk_pend_in = 1'b1;
         end
         if (wk_pend_ff && !skip) begin
            if (!rd_data_ff[31])
               ok_in = (!spin_ff && d_up > 18'sd256) || (spin_ff && d_down > 18'sd256);
            else if (!spin_ff)
               spin_in = 1'b1;
            lastx_in = sx_bias[15:8];
         end
         if (walk_done) begin
            if (ok_ff)
               g_in = (sign_ff == tgd_pkg::SIGN_POS) ? tgd_pkg::GEST_LEFT
                                                     : tgd_pkg::GEST_RIGHT;
            clr = 1'b1;
         end
      end

      if (cmd.post) begin
         if (op_ff == tgd_pkg::OP_ACCEL) begin
            if (abs_x > {1'b0, cfg.x_min} && cnt_ff < CW'(SAMPLE_DEPTH)) begin
               mem_we = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            if (abs_z > {1'b0, cfg.z_reset_limit})
               clr = 1'b1;
         end else if (ori_ff == tgd_pkg::ORI_TOP_DOWN || ori_ff == tgd_pkg::ORI_FACE_DOWN) begin
            clr = 1'b1;
         end
      end

      if (clr) begin
         detect_in = 1'b0;
         check_in  = 1'b0;
         cnt_in    = '0;
         rise_in   = '0;
         fall_in   = '0;
         prev_in   = '0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_gesture_in = rsp_gesture_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_gesture_in = g_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         hist_ff      <= '{default: '0};
         ocnt_ff      <= '0;
         detect_ff    <= 1'b0;
         check_ff     <= 1'b0;
         rise_ff      <= '0;
         fall_ff      <= '0;
         prev_ff      <= '0;
         sign_ff      <= tgd_pkg::SIGN_ZERO;
         head_ff      <= '0;
         cnt_ff       <= '0;
         chk_pend_ff  <= 1'b0;
         wk_idx_ff    <= '0;
         wk_pend_ff   <= 1'b0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         hist_ff      <= hist_in;
         ocnt_ff      <= ocnt_in;
         detect_ff    <= detect_in;
         check_ff     <= check_in;
         rise_ff      <= rise_in;
         fall_ff      <= fall_in;
         prev_ff      <= prev_in;
         sign_ff      <= sign_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         chk_pend_ff  <= chk_pend_in;
         wk_idx_ff    <= wk_idx_in;
         wk_pend_ff   <= wk_pend_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      z_ff           <= z_in;
      ori_ff         <= ori_in;
      g_ff           <= g_in;
      rem_ff         <= rem_in;
      res_ff         <= res_in;
      vx_ff          <= vx_in;
      vy_ff          <= vy_in;
      acc_ff         <= acc_in;
      spin_ff        <= spin_in;
      ok_ff          <= ok_in;
      lastx_ff       <= lastx_in;
      rsp_gesture_ff <= rsp_gesture_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         sample_mem[mem_wa] <= mem_wd;
      if (mem_re)
         rd_data_ff <= sample_mem[mem_ra];
   end

   assign sts.is_orient = (req_op == tgd_pkg::OP_ORIENT);
   assign sts.acc_skip  = (req_op == tgd_pkg::OP_ACCEL) && !seen_ff;
   assign sts.iter_last = (iter_ff == tgd_pkg::ITER_W'(tgd_pkg::CORDIC_STEPS - 1));
   assign sts.chk_pend  = chk_pend_ff;
   assign sts.need_walk = (sign_ff != tgd_pkg::SIGN_NEG) && (ocnt_ff >= 2'd2) &&
                          !orule && !low_counts && !high_counts;
   assign sts.walk_done = walk_done;
   assign sts.rsp_busy  = rsp_valid_ff && rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_gesture = rsp_gesture_ff;

endmodule

// ===== verif/twist_gesture_detector_unit_test.sv =====
// Self-checking bench for twist_gesture_detector_unit: directed table, then random traffic.
// Expected gestures come from a behavioral tracker model; depends on tgd_pkg and the RTL.
`timescale 1ns / 1ps

module twist_gesture_detector_unit_test;

   localparam int DEPTH      = 32;
   localparam int IDLE_LIMIT = 20000;
   localparam int N_RANDOM   = 850;
   localparam int N_DIRECTED = 25;
   localparam logic [1:0] G_ANY = 2'd3;   // directed row: check against tracker only

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [14:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = 1'b0;
   logic signed [15:0] req_accel_x = '0, req_accel_y = '0, req_accel_z = '0;
   logic [2:0] req_orientation = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_gesture;

   twist_gesture_detector_unit #(.SAMPLE_DEPTH(DEPTH)) dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------- tracker model ----------------
   tgd_pkg::cfg_type cfg;
   bit seen_ori;
   logic [2:0] hist [3];
   int unsigned hist_n;
   bit detecting, checking;
   int unsigned rises, falls;
   int last_tilt;
   logic [1:0] sign_code;
   logic [31:0] swing_buf [DEPTH];
   int unsigned swing_n;

   logic [1:0] gesture_queue [$];
   int errors = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;          // last part of run: no idling
   int rsp_burst = 0;

   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint isqrt(longint unsigned s);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic int tilt_of(int x, int y, int z);
      longint vx, vy, acc, dx, dy, a;
      acc = 0;
      if (x == 0) return 0;
      vx = isqrt(longint'(y) * y + longint'(z) * z) * 256;
      vy = longint'(x) * 256;
      for (int i = 0; i < tgd_pkg::CORDIC_STEPS; i++) begin
         dx = fshift(vy, i);
         dy = fshift(vx, i);
         if (vy >= 0) begin
            vx += dx; vy -= dy;
            acc += longint'(tgd_pkg::atan_entry(tgd_pkg::ITER_W'(i)));
         end else begin
            vx -= dx; vy += dy;
            acc -= longint'(tgd_pkg::atan_entry(tgd_pkg::ITER_W'(i)));
         end
      end
      a = fshift(acc + 256, 9);
      if (a > tgd_pkg::ANGLE_LIMIT) a = tgd_pkg::ANGLE_LIMIT;
      if (a < -tgd_pkg::ANGLE_LIMIT) a = -tgd_pkg::ANGLE_LIMIT;
      return int'(a);
   endfunction

   function automatic int mag(int v);
      return v < 0 ? -v : v;
   endfunction

   task automatic tracker_clear();
      detecting = 0; checking = 0; swing_n = 0;
      rises = 0; falls = 0; last_tilt = 0;
   endtask

   task automatic tracker_reset();
      cfg = '{min_angle: 14'd256, detect_angle: 14'd3840, return_angle: 14'd3200,
              z_reset_limit: 15'd3840, x_min: 15'd256};
      seen_ori = 0; hist_n = 0; sign_code = tgd_pkg::SIGN_ZERO;
      foreach (hist[i]) hist[i] = '0;
      tracker_clear();
   endtask

   function automatic logic [1:0] middle_sign();
      return hist[1] == tgd_pkg::ORI_RIGHT_UP ? tgd_pkg::SIGN_POS : tgd_pkg::SIGN_NEG;
   endfunction

   task automatic twist_check(output logic [1:0] g);
      bit ok, spin;
      int lastx, sx, sz;
      ok = 0; spin = 0; lastx = 0; g = tgd_pkg::GEST_NONE;
      checking = 1;
      if (sign_code == tgd_pkg::SIGN_NEG) begin
         tracker_clear();
         return;
      end
      if (hist_n < 2) return;
      if (hist_n > 2 && hist[0] == hist[2] &&
          (hist[1] == tgd_pkg::ORI_LEFT_UP || hist[1] == tgd_pkg::ORI_RIGHT_UP)) begin
         ok = 1; sign_code = middle_sign();
      end
      if (!ok) begin
         if (rises < 1 || falls < 3) return;
         if (rises > 6 && falls > 4) begin
            ok = 1; sign_code = middle_sign();
         end
      end
      if (!ok) begin
         for (int i = 0; i < swing_n; i++) begin
            sx = int'($signed(swing_buf[i][15:0]));
            sz = int'($signed(swing_buf[i][31:16]));
            if (!spin && mag(sx) < tgd_pkg::ONE_UNIT) continue;
            if (sz >= 0) begin
               if (!spin && sx - lastx * tgd_pkg::ONE_UNIT > tgd_pkg::ONE_UNIT) ok = 1;
               else if (spin && lastx * tgd_pkg::ONE_UNIT - sx > tgd_pkg::ONE_UNIT) ok = 1;
               else ok = 0;
            end else if (!spin) begin
               spin = 1;
            end
            lastx = sx / tgd_pkg::ONE_UNIT;   // truncates toward zero
         end
      end
      if (ok) g = (sign_code == tgd_pkg::SIGN_POS) ? tgd_pkg::GEST_LEFT
                                                   : tgd_pkg::GEST_RIGHT;
      tracker_clear();
   endtask

   task automatic predict_gesture(input logic op, input int x, input int y, input int z,
                                  input logic [2:0] ori, output logic [1:0] g);
      int a;
      g = tgd_pkg::GEST_NONE;
      if (op == tgd_pkg::OP_ORIENT) begin
         seen_ori = 1;
         if (hist_n >= 3) begin
            hist[0] = hist[1]; hist[1] = hist[2]; hist_n = 2;
         end
         hist[hist_n] = ori;
         hist_n++;
         if (hist_n == 3 && hist[2] == tgd_pkg::ORI_FACE_UP &&
             (hist[1] == tgd_pkg::ORI_RIGHT_UP || hist[1] == tgd_pkg::ORI_LEFT_UP))
            twist_check(g);
         if (ori == tgd_pkg::ORI_TOP_DOWN || ori == tgd_pkg::ORI_FACE_DOWN) tracker_clear();
         return;
      end
      if (!seen_ori) return;
      if (!detecting && !checking && swing_n > tgd_pkg::TRIM_LIMIT) begin
         for (int i = 0; i + 1 < swing_n; i++) swing_buf[i] = swing_buf[i+1];
         swing_n--;
      end
      a = tilt_of(x, y, z);
      if (mag(a) > int'(cfg.min_angle)) begin
         if (detecting) begin
            if ((a > 0 && a < last_tilt) || (a < 0 && a > last_tilt)) begin
               if (falls < tgd_pkg::SAT_MAX) falls++;
            end else if (falls > 0) begin
               falls--;
            end
         end
         if (!detecting && ((a > 0 && a > last_tilt) || (a < 0 && a < last_tilt)) &&
             ((a > 0 && last_tilt > 0) || (a < 0 && last_tilt < 0))) begin
            if (rises < tgd_pkg::SAT_MAX) rises++;
         end else if (!detecting && rises > 3 && mag(a) > int'(cfg.detect_angle)) begin
            falls = 0; detecting = 1;
            sign_code = y > 0 ? tgd_pkg::SIGN_POS
                              : (y < 0 ? tgd_pkg::SIGN_NEG : tgd_pkg::SIGN_ZERO);
         end
      end else begin
         rises = 0;
      end
      last_tilt = a;
      if (detecting && falls >= 4 && mag(a) < int'(cfg.return_angle)) twist_check(g);
      if (mag(x) > int'(cfg.x_min) && swing_n < DEPTH) begin
         swing_buf[swing_n] = {z[15:0], x[15:0]};
         swing_n++;
      end
      if (mag(z) > int'(cfg.z_reset_limit)) tracker_clear();
   endtask

   // ---------------- drivers ----------------
   // valid stays up between back-to-back transactions; an idle burst drops it
   task automatic send(input logic op, input int x, input int y, input int z,
                       input logic [2:0] ori, input logic [1:0] typed);
      logic [1:0] g;
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_accel_x <= x[15:0];
      req_accel_y <= y[15:0];
      req_accel_z <= z[15:0];
      req_orientation <= ori;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_gesture(op, x, y, z, ori, g);
      if (typed != G_ANY && typed != g) begin
         errors++;
         if (mismatches++ < 10)
            $display("directed row disagrees: expected %0d tracker %0d", typed, g);
      end
      gesture_queue.push_back(g);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (gesture_queue.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // csr_valid stays up across a run of writes; write_all drops it
   task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         tgd_pkg::CSR_MIN_ANGLE:    cfg.min_angle = val[13:0];
         tgd_pkg::CSR_DETECT_ANGLE: cfg.detect_angle = val[13:0];
         tgd_pkg::CSR_RETURN_ANGLE: cfg.return_angle = val[13:0];
         tgd_pkg::CSR_Z_RESET:      cfg.z_reset_limit = val;
         tgd_pkg::CSR_X_MIN:        cfg.x_min = val;
         default: ;
      endcase
   endtask

   task automatic write_all(input int ma, input int da, input int ra, input int zl,
                            input int xm);
      drain();
      write_reg(tgd_pkg::CSR_MIN_ANGLE, ma[14:0]);
      write_reg(tgd_pkg::CSR_DETECT_ANGLE, da[14:0]);
      write_reg(tgd_pkg::CSR_RETURN_ANGLE, ra[14:0]);
      write_reg(tgd_pkg::CSR_Z_RESET, zl[14:0]);
      write_reg(tgd_pkg::CSR_X_MIN, xm[14:0]);
      csr_valid <= 1'b0;
   endtask

   function automatic int rnd16();
      return int'($signed(16'($urandom)));
   endfunction

   // Well-formed twist: tilt ramps up past detect, then returns toward flat.
   task automatic twist_burst();
      int peak, x, y, z, steps;
      y = $urandom_range(0, 1) ? 2000 : -2000;
      if ($urandom_range(0, 5) == 0) y = 0;
      steps = $urandom_range(5, 10);
      peak = $urandom_range(1800, 3000) * ($urandom_range(0, 1) ? 1 : -1);
      z = $urandom_range(0, 1) ? $urandom_range(0, 900) : -int'($urandom_range(0, 900));
      for (int i = 1; i <= steps; i++) begin
         x = peak * i / steps + int'($urandom_range(0, 30));
         send(tgd_pkg::OP_ACCEL, x, y, z, 3'($urandom), G_ANY);
      end
      for (int i = steps; i >= 0; i--) begin
         x = peak * i / steps;
         z = $urandom_range(0, 3) == 0 ? -int'($urandom_range(0, 900))
                                        : int'($urandom_range(0, 900));
         send(tgd_pkg::OP_ACCEL, x, y, z, 3'($urandom), G_ANY);
      end
   endtask

   task automatic orient_seq();
      logic [2:0] mid;
      mid = $urandom_range(0, 1) ? tgd_pkg::ORI_LEFT_UP : tgd_pkg::ORI_RIGHT_UP;
      send(tgd_pkg::OP_ORIENT, rnd16(), rnd16(), rnd16(), tgd_pkg::ORI_FACE_UP, G_ANY);
      send(tgd_pkg::OP_ORIENT, rnd16(), rnd16(), rnd16(), mid, G_ANY);
      send(tgd_pkg::OP_ORIENT, rnd16(), rnd16(), rnd16(),
           $urandom_range(0, 4) != 0 ? tgd_pkg::ORI_FACE_UP : 3'($urandom), G_ANY);
   endtask

   // ---------------- directed table ----------------
   typedef struct {
      logic op;
      int x, y, z;
      logic [2:0] ori;
      logic [1:0] g;
   } row_type;

   row_type directed [N_DIRECTED] = '{
      // samples before any orientation are ignored
      '{tgd_pkg::OP_ACCEL, 32767, 0, 0, 3'd0, tgd_pkg::GEST_NONE},
      '{tgd_pkg::OP_ACCEL, -32768, -32768, -32768, 3'd7, tgd_pkg::GEST_NONE},
      '{tgd_pkg::OP_ORIENT, -32768, 32767, -1, 3'd0, tgd_pkg::GEST_NONE},
      '{tgd_pkg::OP_ORIENT, 0, 0, 0, 3'd7, tgd_pkg::GEST_NONE},
      '{tgd_pkg::OP_ACCEL, 0, 0, 0, 3'd0, G_ANY},
      '{tgd_pkg::OP_ACCEL, 32767, 32767, 32767, 3'd0, G_ANY},
      '{tgd_pkg::OP_ACCEL, -32768, 0, 0, 3'd0, G_ANY},
      '{tgd_pkg::OP_ACCEL, 300, -32768, 100, 3'd0, G_ANY},
      // face up, right up, face up: orientation rule
      '{tgd_pkg::OP_ORIENT, 0, 0, 0, tgd_pkg::ORI_FACE_UP, G_ANY},
      '{tgd_pkg::OP_ORIENT, 0, 0, 0, tgd_pkg::ORI_RIGHT_UP, G_ANY},
      '{tgd_pkg::OP_ORIENT, 0, 0, 0, tgd_pkg::ORI_FACE_UP, G_ANY},
      '{tgd_pkg::OP_ORIENT, 0, 0, 0, tgd_pkg::ORI_LEFT_UP, G_ANY},
      '{tgd_pkg::OP_ORIENT, 0, 0, 0, tgd_pkg::ORI_FACE_UP, G_ANY},
      '{tgd_pkg::OP_ORIENT, 0, 0, 0, tgd_pkg::ORI_TOP_DOWN, G_ANY},
      '{tgd_pkg::OP_ORIENT, 0, 0, 0, tgd_pkg::ORI_FACE_DOWN, G_ANY},
      '{tgd_pkg::OP_ORIENT, 0, 0, 0, 3'd1, G_ANY},
      // ramp and return
      '{tgd_pkg::OP_ACCEL, 500, 2000, 0, 3'd0, G_ANY},
      '{tgd_pkg::OP_ACCEL, 1000, 2000, 0, 3'd0, G_ANY},
      '{tgd_pkg::OP_ACCEL, 1500, 2000, 0, 3'd0, G_ANY},
      '{tgd_pkg::OP_ACCEL, 2000, 2000, 0, 3'd0, G_ANY},
      '{tgd_pkg::OP_ACCEL, 2600, 2000, -500, 3'd0, G_ANY},
      '{tgd_pkg::OP_ACCEL, 1500, 2000, 0, 3'd0, G_ANY},
      '{tgd_pkg::OP_ACCEL, 900, 2000, 0, 3'd0, G_ANY},
      '{tgd_pkg::OP_ACCEL, 400, 2000, 0, 3'd0, G_ANY},
      '{tgd_pkg::OP_ACCEL, 100, 2000, 5000, 3'd0, G_ANY}
   };

   // ---------------- response side ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_burst <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (gesture_queue.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("gesture %0d with none expected", rsp_gesture);
            end else begin
               if (rsp_gesture !== gesture_queue[0]) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("gesture mismatch: expected %0d actual %0d",
                              gesture_queue[0], rsp_gesture);
               end
               void'(gesture_queue.pop_front());
            end
         end
         // random stall bursts on the response side
         if (rsp_burst > 0) begin
            rsp_burst <= rsp_burst - 1;
            rsp_stall <= (rsp_burst > 1);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_burst <= $urandom_range(1, 11);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------- main sequence ----------------
   initial begin
      int n, kind;
      tracker_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send(directed[i].op, directed[i].x, directed[i].y, directed[i].z,
              directed[i].ori, directed[i].g);

      // hold the sender until every result is back
      drain();

      n = 0;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_all(256, 3840, 3200, 3840, 256);
            1: write_all(0, 0, 11520, 32767, 0);
            2: write_all(11520, 11520, 0, 0, 32767);
            3: write_all($urandom_range(0, 600), $urandom_range(1500, 4000),
                         $urandom_range(1500, 4000), $urandom_range(2000, 32767),
                         $urandom_range(0, 600));
            default: write_all(16383, 16383, 16383, 32767, 256);
         endcase
         if (phase == 4) quiet = 1'b1;
         while (n < (phase + 1) * N_RANDOM / 5) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
               twist_burst(); n += 16;
            end else if (kind < 6) begin
               orient_seq(); n += 3;
            end else if (kind < 8) begin
               send(tgd_pkg::OP_ACCEL, rnd16() / 8, rnd16() / 8, rnd16() / 8,
                    3'($urandom), G_ANY);
               n++;
            end else begin
               send(1'($urandom_range(0, 1)), rnd16(), rnd16(), rnd16(), 3'($urandom),
                    G_ANY);
               n++;
            end
         end
      end

      drain();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tgd_pkg.sv
rtl/tgd_ctrl.sv
rtl/tgd_datapath.sv
rtl/twist_gesture_detector_unit.sv
verif/twist_gesture_detector_unit_test.sv
